// ===== rtl/pnghc_pkg.sv =====
// Shared types, constants and the CRC-32 byte update for the PNG chunk CRC checker
`timescale 1ns / 1ps

package pnghc_pkg;

  // report kinds
  localparam logic [1:0] KIND_NOT_PNG = 2'd0;
  localparam logic [1:0] KIND_DIMS    = 2'd1;
  localparam logic [1:0] KIND_CRC     = 2'd2;
  localparam logic [1:0] KIND_TRUNC   = 2'd3;

  // report queue depth, pointer width and count width
  localparam int RPT_DEPTH = 8;
  localparam int RPT_PTR_W = $clog2(RPT_DEPTH);
  localparam int RPT_CNT_W = $clog2(RPT_DEPTH + 1);

  // reflected CRC-32 polynomial
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // PNG file signature
  localparam logic [7:0] PNG_SIG [8] = '{8'h89, 8'h50, 8'h4e, 8'h47,
                                         8'h0d, 8'h0a, 8'h1a, 8'h0a};

  // input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  // output beat
  typedef struct packed {
    logic [1:0]  report_kind;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [1:0]  chunk_number;
    logic [31:0] computed_crc;
    logic [31:0] stored_crc;
    logic        crc_match;
    logic        report_end;
  } out_t;

  // reports produced by one byte, handed to the queue
  typedef struct packed {
    logic [1:0] num;
    out_t       rpt0;
    out_t       rpt1;
  } rpt_push_t;

  // one byte of the reflected CRC-32
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ===== rtl/pnghc_parse.sv =====
// Byte parser: signature check, dimension capture, chunk framing and CRC update
`timescale 1ns / 1ps

module pnghc_parse #(
  parameter int CHUNKS_CHECKED = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  pnghc_pkg::in_t       item,
  output pnghc_pkg::rpt_push_t push
);

  localparam logic [2:0] PH_SIG  = 3'd0;
  localparam logic [2:0] PH_LEN  = 3'd1;
  localparam logic [2:0] PH_TYPE = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CRC  = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;
  localparam logic [2:0] PH_SKIP = 3'd6;

  // file position saturates once past the last header byte of interest
  localparam logic [4:0] POS_SAT    = 5'd24;
  localparam logic [1:0] CHUNK_LAST = 2'(CHUNKS_CHECKED);

  logic [2:0]  phase, phase_next;
  logic [4:0]  pos, pos_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] crc, crc_next;
  logic [31:0] trailer, trailer_next;
  logic [1:0]  chunk_idx, chunk_idx_next;
  logic [31:0] width_hold, width_hold_next;
  logic [31:0] height_hold, height_hold_next;
  logic [1:0]  field_cnt, field_cnt_next;

  logic [7:0]  b;
  logic [31:0] word;
  logic [31:0] crc_upd;
  logic [31:0] crc_final;
  logic        last_chunk;
  logic        complete;
  logic        dims_v, chk_v, trunc_v;
  pnghc_pkg::out_t dims_rpt, chk_rpt, trunc_rpt;

  assign b         = item.data_byte;
  assign word      = {trailer[23:0], b};
  assign crc_upd   = pnghc_pkg::crc_byte(crc, b);
  assign crc_final = ~crc;

  // next state and reports for the byte in the input register
  always_comb begin
    phase_next       = phase;
    pos_next         = pos;
    chunk_length_next = chunk_length;
    crc_next         = crc;
    trailer_next     = trailer;
    chunk_idx_next   = chunk_idx;
    width_hold_next  = width_hold;
    height_hold_next = height_hold;
    field_cnt_next   = field_cnt;
    last_chunk       = 1'b0;
    complete         = 1'b1;
    dims_v           = 1'b0;
    chk_v            = 1'b0;
    trunc_v          = 1'b0;
    dims_rpt         = '0;
    chk_rpt          = '0;
    trunc_rpt        = '0;

    if (item_valid) begin
      // dimension capture runs alongside chunk parsing
      if (phase != PH_SIG && phase != PH_SKIP) begin
        if (pos >= 5'd16 && pos <= 5'd19) begin
          width_hold_next = {width_hold[23:0], b};
        end else if (pos >= 5'd20 && pos <= 5'd23) begin
          height_hold_next = {height_hold[23:0], b};
        end
        if (pos == 5'd23) begin
          dims_v                = 1'b1;
          dims_rpt.report_kind  = pnghc_pkg::KIND_DIMS;
          dims_rpt.image_width  = width_hold_next;
          dims_rpt.image_height = height_hold_next;
          dims_rpt.report_end   = (phase == PH_DONE);
        end
      end

      case (phase)
        PH_SIG: begin
          if (b != pnghc_pkg::PNG_SIG[pos[2:0]]) begin
            chk_v               = 1'b1;
            chk_rpt.report_kind = pnghc_pkg::KIND_NOT_PNG;
            chk_rpt.report_end  = 1'b1;
            phase_next          = PH_SKIP;
          end else if (pos == 5'd7) begin
            phase_next     = PH_LEN;
            field_cnt_next = 2'd0;
            trailer_next   = '0;
          end
        end
        PH_LEN: begin
          trailer_next = word;
          if (field_cnt == 2'd3) begin
            field_cnt_next    = 2'd0;
            chunk_length_next = word;
            trailer_next      = '0;
            crc_next          = '1;
            phase_next        = PH_TYPE;
          end else begin
            field_cnt_next = field_cnt + 2'd1;
          end
        end
        PH_TYPE: begin
          crc_next = crc_upd;
          if (field_cnt == 2'd3) begin
            field_cnt_next = 2'd0;
            phase_next     = (chunk_length != '0) ? PH_DATA : PH_CRC;
          end else begin
            field_cnt_next = field_cnt + 2'd1;
          end
        end
        PH_DATA: begin
          crc_next          = crc_upd;
          chunk_length_next = chunk_length - 32'd1;
          if (chunk_length_next == '0) begin
            phase_next = PH_CRC;
          end
        end
        PH_CRC: begin
          trailer_next = word;
          if (field_cnt == 2'd3) begin
            field_cnt_next       = 2'd0;
            chunk_idx_next       = chunk_idx + 2'd1;
            last_chunk           = (chunk_idx_next >= CHUNK_LAST);
            chk_v                = 1'b1;
            chk_rpt.report_kind  = pnghc_pkg::KIND_CRC;
            chk_rpt.chunk_number = chunk_idx;
            chk_rpt.computed_crc = crc_final;
            chk_rpt.stored_crc   = word;
            chk_rpt.crc_match    = (crc_final == word);
            chk_rpt.report_end   = last_chunk && (pos >= 5'd23);
            trailer_next         = '0;
            crc_next             = '1;
            phase_next           = last_chunk ? PH_DONE : PH_LEN;
          end else begin
            field_cnt_next = field_cnt + 2'd1;
          end
        end
        default: begin
        end
      endcase

      pos_next = (pos == POS_SAT) ? pos : pos + 5'd1;

      // end of file: flag truncation, then rearm
      if (item.final_byte) begin
        complete = (phase_next == PH_SKIP) || (phase_next == PH_DONE && pos >= 5'd23);
        trunc_v  = !complete;
        trunc_rpt.report_kind = pnghc_pkg::KIND_TRUNC;
        trunc_rpt.report_end  = 1'b1;
        phase_next        = PH_SIG;
        pos_next          = '0;
        chunk_length_next = '0;
        crc_next          = '1;
        trailer_next      = '0;
        chunk_idx_next    = '0;
        width_hold_next   = '0;
        height_hold_next  = '0;
        field_cnt_next    = '0;
      end
    end
  end

  // pack up to two reports; dimension report yields when three fall due
  always_comb begin
    push.rpt0 = (dims_v && !(chk_v && trunc_v)) ? dims_rpt : (chk_v ? chk_rpt : trunc_rpt);
    push.rpt1 = trunc_v ? trunc_rpt : chk_rpt;
    if ((dims_v && chk_v) || (dims_v && trunc_v) || (chk_v && trunc_v)) begin
      push.num = 2'd2;
    end else if (dims_v || chk_v || trunc_v) begin
      push.num = 2'd1;
    end else begin
      push.num = 2'd0;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SIG;
      pos          <= '0;
      chunk_length <= '0;
      crc          <= '1;
      trailer      <= '0;
      chunk_idx    <= '0;
      width_hold   <= '0;
      height_hold  <= '0;
      field_cnt    <= '0;
    end else begin
      phase        <= phase_next;
      pos          <= pos_next;
      chunk_length <= chunk_length_next;
      crc          <= crc_next;
      trailer      <= trailer_next;
      chunk_idx    <= chunk_idx_next;
      width_hold   <= width_hold_next;
      height_hold  <= height_hold_next;
      field_cnt    <= field_cnt_next;
    end
  end

endmodule

// ===== rtl/pnghc_rpt_fifo.sv =====
// Report queue: takes up to two reports a cycle, hands out one beat a cycle while pop is high
`timescale 1ns / 1ps

module pnghc_rpt_fifo (
  input  logic                                clk,
  input  logic                                rst,
  input  pnghc_pkg::rpt_push_t                push,
  input  logic                                pop,
  output pnghc_pkg::out_t                     head,
  output logic [pnghc_pkg::RPT_CNT_W-1:0]     count
);

  localparam int PW = pnghc_pkg::RPT_PTR_W;
  localparam int CW = pnghc_pkg::RPT_CNT_W;

  pnghc_pkg::out_t mem [pnghc_pkg::RPT_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr + PW'(1);
  assign head      = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.rpt0;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr_p1] <= push.rpt1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.num);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + CW'(push.num) - CW'(pop);
    end
  end

endmodule

// ===== rtl/png_header_chunk_crc_checker_core.sv =====
// Top level of the PNG header and chunk CRC checker
`timescale 1ns / 1ps

// Usage
//   Input channel (item_valid / item_stall / item): one file byte per beat,
//   final_byte marks the last byte of a file; the block rearms after it.
//   Output channel (report_valid / report_stall / report): one report per
//   beat - not png, dimensions, chunk CRC check or truncated stream;
//   report_end marks the last report of a file.
//   Timing: a byte is registered on acceptance and parsed in the next cycle;
//   its reports are written into the report queue, and the head of the
//   queue drives the output.
//   Throughput: one byte per cycle while item_stall is low. The CRC-32 byte
//   update, the counters and the compares all sit after the input register.
//   The report queue holds eight beats. item_stall rises when the queue
//   could not take the two reports a byte may cause (three or more entries
//   used while a byte is in flight, five or more otherwise); a stalled
//   receiver thus backs up into the input only after reports pile up.
//   Reset (rst, synchronous): empties the queue, drops the byte in flight
//   and returns the parser to the signature check.

module png_header_chunk_crc_checker_core #(
  parameter int CHUNKS_CHECKED = 3
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  pnghc_pkg::in_t  item,
  output logic            report_valid,
  input  logic            report_stall,
  output pnghc_pkg::out_t report
);

  localparam int CW = pnghc_pkg::RPT_CNT_W;

  logic                 in_q_valid;
  pnghc_pkg::in_t       in_q;
  pnghc_pkg::rpt_push_t push;
  logic [CW-1:0]        fifo_count;
  logic [CW:0]          reserved;
  logic                 pop;

  // room for the byte in flight and the new one
  assign reserved   = {1'b0, fifo_count} + (in_q_valid ? (CW+1)'(2) : '0);
  assign item_stall = (reserved > (CW+1)'(pnghc_pkg::RPT_DEPTH - 4));

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else begin
      in_q_valid <= item_valid && !item_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_q <= item;
    end
  end

  pnghc_parse #(
    .CHUNKS_CHECKED(CHUNKS_CHECKED)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .item_valid(in_q_valid),
    .item      (in_q),
    .push      (push)
  );

  // output beat handshake
  assign report_valid = (fifo_count != '0);
  assign pop          = report_valid && !report_stall;

  pnghc_rpt_fifo u_rpt_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (report),
    .count(fifo_count)
  );

  // queue never overfills
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= CW'(pnghc_pkg::RPT_DEPTH))
    else $error("report queue overflow");

  // no reports without a byte in the input register
  a_push_needs_byte: assert property (@(posedge clk) disable iff (rst)
    !in_q_valid |-> push.num == 2'd0)
    else $error("report pushed with no byte in flight");

  // match flag agrees with the two CRC values
  a_match_flag: assert property (@(posedge clk) disable iff (rst)
    report_valid && report.report_kind == pnghc_pkg::KIND_CRC |->
      report.crc_match == (report.computed_crc == report.stored_crc))
    else $error("crc match flag inconsistent");

  // nothing on the output right after reset
  a_quiet_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !report_valid)
    else $error("report beat right after reset");

endmodule
